// File: rtl/pnrq_pkg.sv
// Shared types and constants for the per-node resource quota block.
package pnrq_pkg;

    localparam int NODES_DEF = 16;
    localparam int RES_NUM   = 4;
    localparam int RES_W     = 2;
    localparam int CNT_W     = 32;
    localparam int BASE_W    = 31;
    localparam int NODE_W    = 8;
    localparam int ROW_W     = RES_NUM * CNT_W;

    typedef enum logic [1:0] {
        REQ_CONSUME = 2'd0,
        REQ_QUERY   = 2'd1,
        REQ_EXPIRE  = 2'd2,
        REQ_SET_DBL = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NODE_ERR = 2'd1,
        ST_QUOTA    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

endpackage

// File: rtl/pnrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pnrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pnrq_alu.sv
// Shared add and compare unit: counter plus amount, checked against the limit.
module pnrq_alu
    import pnrq_pkg::*;
(
    input  logic [CNT_W-1:0] i_cur,
    input  logic [CNT_W-1:0] i_amount,
    input  logic [CNT_W-1:0] i_limit,
    output logic [CNT_W-1:0] o_sum,
    output logic             o_over
);

    logic [CNT_W:0] w_sum;

    // sum kept one bit wider so it never wraps
    assign w_sum  = {1'b0, i_cur} + {1'b0, i_amount};
    assign o_sum  = w_sum[CNT_W-1:0];
    assign o_over = w_sum > {1'b0, i_limit};

endmodule

// File: rtl/per_node_resource_quota_top.sv
// Top level of the per-node resource quota block: sequencer, flags, limits, table.
//
// Usage: a request (req_type, node, resource, amount, arm) is transferred at a
// rising edge with start high and busy low. busy stays high until the result
// has been driven. Each request gives one result (status, used, limit,
// doubling_armed) on the o_ ports for one cycle with o_valid high; the
// receiver cannot stall, so the result must be taken in that cycle.
// Sequence: start transfer -> table read (S_READ) -> add/compare/write back
// (S_EXEC) -> result cycle. o_valid is registered from S_EXEC, and a new
// request may be started while o_valid is high, so requests never overlap;
// this is set by the registered read of the counter memory and the single
// shared adder/comparator. The counter table holds one row of four 32-bit
// counters per node. A valid bit per row, cleared at reset and by expire,
// makes unwritten rows read as zero, so expire goes through the same
// sequence as the other requests.
// Base limits are written on the cfg channel (index 0..3, 31-bit data),
// always ready; writes are expected only while busy is low.
// Reset (i_rst_n low, synchronous) clears limits, flags and row valid bits.
module per_node_resource_quota_top
    import pnrq_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_req_type,
    input  logic [NODE_W-1:0] i_node,
    input  logic [RES_W-1:0]  i_resource,
    input  logic [CNT_W-1:0]  i_amount,
    input  logic              i_arm,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [CNT_W-1:0]  o_used,
    output logic [CNT_W-1:0]  o_limit,
    output logic              o_doubling_armed,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [RES_W-1:0]  i_cfg_index,
    input  logic [BASE_W-1:0] i_cfg_data
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

    t_state r_state, n_state;

    logic [BASE_W-1:0] r_base [RES_NUM];
    logic              r_doubled, n_doubled;
    logic              r_pending, n_pending;
    logic [NODES-1:0]  r_row_valid;

    t_req              r_req;
    logic              r_node_ok;
    logic [AW-1:0]     r_addr;
    logic [RES_W-1:0]  r_res;
    logic [CNT_W-1:0]  r_amount;
    logic              r_arm;

    logic              r_valid;
    t_status           r_status, n_status;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  r_limit, n_limit;
    logic              r_armed;

    logic              w_accept;
    logic              w_we;
    logic              w_row_clear;
    logic [ROW_W-1:0]  w_rdata;
    logic [ROW_W-1:0]  w_row;
    logic [ROW_W-1:0]  w_wrow;
    logic [CNT_W-1:0]  w_cur;
    logic [CNT_W-1:0]  w_lim_now;
    logic [CNT_W-1:0]  w_lim_new;
    logic [BASE_W-1:0] w_base;
    logic [CNT_W-1:0]  w_sum;
    logic              w_over;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ---------------- counter table ----------------
    pnrq_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_wrow),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // rows never written since the last expire read as zero
    assign w_row  = r_row_valid[r_addr] ? w_rdata : '0;
    assign w_cur  = w_row[r_res*CNT_W +: CNT_W];
    assign w_base = r_base[r_res];

    always_comb begin
        w_wrow                        = w_row;
        w_wrow[r_res*CNT_W +: CNT_W]  = w_sum;
    end

    assign w_lim_now = r_doubled ? {w_base, 1'b0} : {1'b0, w_base};
    assign w_lim_new = n_doubled ? {w_base, 1'b0} : {1'b0, w_base};

    pnrq_alu u_alu (
        .i_cur    (w_cur),
        .i_amount (r_amount),
        .i_limit  (w_lim_now),
        .o_sum    (w_sum),
        .o_over   (w_over)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_doubled   = r_doubled;
        n_pending   = r_pending;
        n_status    = ST_OK;
        n_used      = '0;
        n_limit     = '0;
        w_we        = 1'b0;
        w_row_clear = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_req)
                    REQ_CONSUME, REQ_QUERY: begin
                        if (!r_node_ok) begin
                            n_status = ST_NODE_ERR;
                        end else begin
                            n_limit = w_lim_now;
                            n_used  = w_cur;
                            if (r_req == REQ_CONSUME && r_amount != '0) begin
                                if (w_over) begin
                                    n_status = ST_QUOTA;
                                end else begin
                                    n_used = w_sum;
                                    w_we   = 1'b1;
                                end
                            end
                        end
                    end
                    REQ_EXPIRE: begin
                        n_doubled   = r_pending;
                        n_pending   = 1'b0;
                        w_row_clear = 1'b1;
                        n_limit     = w_lim_new;
                    end
                    REQ_SET_DBL: begin
                        n_pending = r_arm;
                        n_limit   = w_lim_new;
                    end
                    default: ;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- control and flags ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doubled   <= 1'b0;
            r_pending   <= 1'b0;
            r_row_valid <= '0;
            r_valid     <= 1'b0;
            for (int i = 0; i < RES_NUM; i++) begin
                r_base[i] <= '0;
            end
        end else begin
            r_doubled <= n_doubled;
            r_pending <= n_pending;
            r_valid   <= (r_state == S_EXEC);
            if (w_row_clear) begin
                r_row_valid <= '0;
            end else if (w_we) begin
                r_row_valid[r_addr] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_base[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    // ---------------- request and result payload ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req     <= t_req'(i_req_type);
            r_node_ok <= ({1'b0, i_node} < 9'(NODES));
            r_addr    <= i_node[AW-1:0];
            r_res     <= i_resource;
            r_amount  <= i_amount;
            r_arm     <= i_arm;
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_used   <= n_used;
            r_limit  <= n_limit;
            r_armed  <= n_pending;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_used           = r_used;
    assign o_limit          = r_limit;
    assign o_doubling_armed = r_armed;

    // ---------------- assertions ----------------
    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EXEC))
        else $error("result strobe without an execute cycle");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_READ))
        else $error("accepted request did not start a table read");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_EXEC && r_node_ok && r_req == REQ_CONSUME))
        else $error("table write outside a valid consume");

    a_node_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NODE_ERR) |-> (o_used == '0 && o_limit == '0))
        else $error("node error result carries data");

    a_expire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_row_clear |=> (r_row_valid == '0 && !r_pending))
        else $error("expire did not clear the table and the pending flag");

endmodule
